// ----- rtl/tld_pkg.sv -----
package tld_pkg;

  localparam int unsigned LINE_MAX_DEF = 64;

  localparam logic [7:0] B_NUL   = 8'd0;
  localparam logic [7:0] B_ETX   = 8'd3;
  localparam logic [7:0] B_EOT   = 8'd4;
  localparam logic [7:0] B_BS    = 8'd8;
  localparam logic [7:0] B_LF    = 8'd10;
  localparam logic [7:0] B_CR    = 8'd13;
  localparam logic [7:0] B_NAK   = 8'd21;
  localparam logic [7:0] B_ETB   = 8'd23;
  localparam logic [7:0] B_SPACE = 8'd32;
  localparam logic [7:0] B_DEL   = 8'd127;
  localparam logic [7:0] B_SE    = 8'd240;
  localparam logic [7:0] B_SB    = 8'd250;
  localparam logic [7:0] B_WILL  = 8'd251;
  localparam logic [7:0] B_WONT  = 8'd252;
  localparam logic [7:0] B_DO    = 8'd253;
  localparam logic [7:0] B_DONT  = 8'd254;
  localparam logic [7:0] B_IAC   = 8'd255;

  typedef enum logic [2:0] {
    EK_NONE = 3'd0,
    EK_BYTE = 3'd1,
    EK_RUB  = 3'd2,
    EK_CRLF = 3'd3,
    EK_INTR = 3'd4,
    EK_DONT = 3'd5,
    EK_WONT = 3'd6
  } echo_kind_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_READABLE = 2'd1,
    EV_EOF      = 2'd2,
    EV_INTR     = 2'd3
  } event_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       arm;
  } tld_in_t;

  typedef struct packed {
    logic       queue_valid;
    logic [7:0] queue_byte;
    echo_kind_e echo_kind;
    logic [7:0] echo_byte;
    event_e     event_res;
    logic       fired_status;
    logic       last;
  } tld_out_t;

endpackage

// ----- rtl/terminal_line_discipline.sv -----
// sequencing: an accepted request is registered, then decoded in S_DEC; a line delivery reads the
// line store and registers each byte in turn, and a word erase reads and checks each byte in turn
// before its erase is registered; output stalls hold every state that writes a result
// flow: the input stalls from acceptance until the final result is registered, so a new request
// is not taken before the last one is through
// reset: control state, line length and interrupt flags clear at once; line store not cleared
module terminal_line_discipline #(
  parameter int unsigned LINE_MAX = tld_pkg::LINE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tld_pkg::tld_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tld_pkg::tld_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);
  import tld_pkg::*;

  localparam int unsigned LW = $clog2(LINE_MAX);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DEC     = 3'd1;
  localparam logic [2:0] S_DLV_RD  = 3'd2;
  localparam logic [2:0] S_DLV_OUT = 3'd3;
  localparam logic [2:0] S_NL      = 3'd4;
  localparam logic [2:0] S_RUBALL  = 3'd5;
  localparam logic [2:0] S_W_RD    = 3'd6;
  localparam logic [2:0] S_W_CHK   = 3'd7;

  localparam logic [2:0] TS_DATA  = 3'd0;
  localparam logic [2:0] TS_IAC   = 3'd1;
  localparam logic [2:0] TS_OPT   = 3'd2;
  localparam logic [2:0] TS_SB    = 3'd3;
  localparam logic [2:0] TS_SBIAC = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [2:0]    ts_q, ts_d;
  logic [7:0]    verb_q, verb_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          armed_q, armed_d;
  logic          fired_q, fired_d;
  logic          raw_q;
  logic          nl_q, nl_d;
  logic          ctrlc_q, ctrlc_d;
  logic          phase_q, phase_d;
  logic          pend_q, pend_d;
  tld_in_t       item_q;
  logic          out_valid_q;
  tld_out_t      out_q;

  logic [7:0]    mem [LINE_MAX];
  logic [7:0]    rdata_q;
  logic          wr_en, rd_en;
  logic [LW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data;

  logic          out_free, emit, data_go, rub;
  tld_out_t      res;
  logic [7:0]    c;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign c           = item_q.data_byte;

  always_comb begin
    state_d = state_q;
    ts_d    = ts_q;
    verb_d  = verb_q;
    len_d   = len_q;
    idx_d   = idx_q;
    armed_d = armed_q;
    fired_d = fired_q;
    nl_d    = nl_q;
    ctrlc_d = ctrlc_q;
    phase_d = phase_q;
    pend_d  = pend_q;
    emit    = 1'b0;
    res     = '0;
    data_go = 1'b0;
    rub     = 1'b0;
    wr_en   = 1'b0;
    wr_addr = len_q;
    wr_data = c;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (out_free) begin
          emit     = 1'b1;
          res.last = 1'b1;
          state_d  = S_IDLE;
          if (item_q.req_type) begin
            if (item_q.arm) begin
              armed_d = 1'b1;
              fired_d = 1'b0;
            end else begin
              res.fired_status = fired_q;
              armed_d = 1'b0;
              fired_d = 1'b0;
            end
          end else begin
            case (ts_q)
              TS_IAC: begin
                if (c == B_IAC) begin
                  ts_d    = TS_DATA;
                  data_go = 1'b1;
                end else if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
                  verb_d = c;
                  ts_d   = TS_OPT;
                end else if (c == B_SB) begin
                  ts_d = TS_SB;
                end else begin
                  ts_d = TS_DATA;
                end
              end
              TS_OPT: begin
                if (verb_q == B_WILL) begin
                  res.echo_kind = EK_DONT;
                  res.echo_byte = c;
                end else if (verb_q == B_DO) begin
                  res.echo_kind = EK_WONT;
                  res.echo_byte = c;
                end
                ts_d = TS_DATA;
              end
              TS_SB: begin
                if (c == B_IAC) begin
                  ts_d = TS_SBIAC;
                end
              end
              TS_SBIAC: begin
                ts_d = (c == B_SE) ? TS_DATA : TS_SB;
              end
              default: begin
                if (c == B_IAC) begin
                  ts_d = TS_IAC;
                end else begin
                  data_go = 1'b1;
                end
              end
            endcase
            if (data_go) begin
              if (c == B_ETX && armed_q) begin
                armed_d       = 1'b0;
                fired_d       = 1'b1;
                len_d         = '0;
                res.echo_kind = EK_INTR;
                res.event_res = EV_INTR;
              end else if (raw_q) begin
                res.queue_valid = 1'b1;
                res.queue_byte  = c;
                res.event_res   = EV_READABLE;
              end else begin
                case (c) inside
                  B_CR, B_LF: begin
                    if (len_q == '0) begin
                      res.queue_valid = 1'b1;
                      res.queue_byte  = B_LF;
                      res.echo_kind   = EK_CRLF;
                      res.event_res   = EV_READABLE;
                    end else begin
                      emit    = 1'b0;
                      nl_d    = 1'b1;
                      idx_d   = '0;
                      state_d = S_DLV_RD;
                    end
                  end
                  B_NUL: begin
                  end
                  B_ETX: begin
                    if (len_q == '0) begin
                      res.echo_kind = EK_INTR;
                    end else begin
                      emit    = 1'b0;
                      ctrlc_d = 1'b1;
                      state_d = S_RUBALL;
                    end
                  end
                  B_EOT: begin
                    if (len_q == '0) begin
                      res.event_res = EV_EOF;
                    end else begin
                      emit    = 1'b0;
                      nl_d    = 1'b0;
                      idx_d   = '0;
                      state_d = S_DLV_RD;
                    end
                  end
                  B_BS, B_DEL: begin
                    if (len_q != '0) begin
                      len_d         = len_q - 1'b1;
                      res.echo_kind = EK_RUB;
                    end
                  end
                  B_NAK: begin
                    if (len_q != '0) begin
                      emit    = 1'b0;
                      ctrlc_d = 1'b0;
                      state_d = S_RUBALL;
                    end
                  end
                  B_ETB: begin
                    emit    = 1'b0;
                    phase_d = 1'b0;
                    pend_d  = 1'b0;
                    state_d = S_W_RD;
                  end
                  default: begin
                    if (c >= B_SPACE && len_q < LW'(LINE_MAX - 1)) begin
                      wr_en         = 1'b1;
                      len_d         = len_q + 1'b1;
                      res.echo_kind = EK_BYTE;
                      res.echo_byte = c;
                    end
                  end
                endcase
              end
            end
          end
        end
      end
      S_DLV_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
        state_d = S_DLV_OUT;
      end
      S_DLV_OUT: begin
        if (out_free) begin
          emit            = 1'b1;
          res.queue_valid = 1'b1;
          res.queue_byte  = rdata_q;
          rd_en           = 1'b1;
          rd_addr         = LW'(idx_q + 1'b1);
          idx_d           = LW'(idx_q + 1'b1);
          if (LW'(idx_q + 1'b1) == len_q) begin
            if (nl_q) begin
              state_d = S_NL;
            end else begin
              res.event_res = EV_READABLE;
              res.last      = 1'b1;
              len_d         = '0;
              state_d       = S_IDLE;
            end
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          emit            = 1'b1;
          res.queue_valid = 1'b1;
          res.queue_byte  = B_LF;
          res.echo_kind   = EK_CRLF;
          res.event_res   = EV_READABLE;
          res.last        = 1'b1;
          len_d           = '0;
          state_d         = S_IDLE;
        end
      end
      S_RUBALL: begin
        if (out_free) begin
          emit = 1'b1;
          if (len_q != '0) begin
            res.echo_kind = EK_RUB;
            len_d         = len_q - 1'b1;
            if (len_q == LW'(1) && !ctrlc_q) begin
              res.last = 1'b1;
              state_d  = S_IDLE;
            end
          end else begin
            res.echo_kind = ctrlc_q ? EK_INTR : EK_NONE;
            res.last      = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      S_W_RD: begin
        rd_en   = 1'b1;
        rd_addr = len_q - 1'b1;
        state_d = S_W_CHK;
      end
      S_W_CHK: begin
        if (out_free) begin
          rub = (len_q != '0) && (!phase_q || rdata_q != B_SPACE);
          res.echo_kind = pend_q ? EK_RUB : EK_NONE;
          if (rub) begin
            // the previous erase is not the final result
            emit    = pend_q;
            pend_d  = 1'b1;
            phase_d = phase_q || (rdata_q != B_SPACE);
            len_d   = len_q - 1'b1;
            state_d = S_W_RD;
          end else begin
            emit     = 1'b1;
            res.last = 1'b1;
            pend_d   = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ts_q        <= TS_DATA;
      verb_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      armed_q     <= 1'b0;
      fired_q     <= 1'b0;
      raw_q       <= 1'b0;
      nl_q        <= 1'b0;
      ctrlc_q     <= 1'b0;
      phase_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ts_q    <= ts_d;
      verb_q  <= verb_d;
      idx_q   <= idx_d;
      armed_q <= armed_d;
      fired_q <= fired_d;
      nl_q    <= nl_d;
      ctrlc_q <= ctrlc_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        raw_q <= cfg_wdata_i;
        len_q <= '0;
      end else begin
        len_q <= len_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction accepted while a previous one is still in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res.last |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after the final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DLV_OUT |-> len_q != '0)
    else $error("line delivery running on an empty line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_W_RD || state_q == S_W_CHK))
    else $error("held word-erase result outside word erase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written while the output register is occupied");
`endif

endmodule

// ----- sim/tb_terminal_line_discipline.sv -----
module tb_terminal_line_discipline;
  import tld_pkg::*;

  localparam int LINE_MAX = LINE_MAX_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS = 15;

  typedef enum logic [2:0] {
    TN_DATA,
    TN_IAC,
    TN_OPT,
    TN_SB,
    TN_SBIAC
  } telnet_state_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tld_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tld_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic     cfg_wdata_i = 1'b0;

  tld_in_t  pending_requests[$];
  tld_out_t awaited_outputs[$];
  tld_out_t step_out[0:LINE_MAX];
  tld_out_t want;
  int       step_count = 0;
  int       failures = 0;
  int       requests_issued = 0;
  int       requests_accepted = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       idle_send[4] = '{0, 64, 0, 11};
  int       idle_recv[4] = '{0, 0, 64, 11};

  // line discipline state as seen from outside
  logic          raw_sel = 1'b0;
  telnet_state_e tn_state = TN_DATA;
  logic [7:0]    tn_verb = 8'd0;
  logic [7:0]    line_buf[LINE_MAX];
  logic [6:0]    line_len = 7'd0;
  logic          intr_armed_q = 1'b0;
  logic          intr_fired_q = 1'b0;

  terminal_line_discipline #(
    .LINE_MAX(LINE_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic emit_result(input logic qv, input logic [7:0] qb, input echo_kind_e ek,
                             input logic [7:0] eb, input event_e ev, input logic fs);
    step_out[step_count].queue_valid  = qv;
    step_out[step_count].queue_byte   = qb;
    step_out[step_count].echo_kind    = ek;
    step_out[step_count].echo_byte    = eb;
    step_out[step_count].event_res    = ev;
    step_out[step_count].fired_status = fs;
    step_out[step_count].last         = 1'b0;
    step_count++;
  endtask

  task automatic rub_char();
    if (line_len != 0) begin
      line_len--;
      emit_result(1'b0, 8'd0, EK_RUB, 8'd0, EV_NONE, 1'b0);
    end
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_len; i++) begin
      emit_result(1'b1, line_buf[i], EK_NONE, 8'd0, EV_NONE, 1'b0);
    end
    line_len = 0;
  endtask

  task automatic discipline_step(input tld_in_t tr);
    logic [7:0] c;
    logic       to_line;
    c = tr.data_byte;
    to_line = 1'b0;
    step_count = 0;
    if (tr.req_type) begin
      if (tr.arm) begin
        emit_result(1'b0, 8'd0, EK_NONE, 8'd0, EV_NONE, 1'b0);
      end else begin
        emit_result(1'b0, 8'd0, EK_NONE, 8'd0, EV_NONE, intr_fired_q);
      end
      intr_fired_q = 1'b0;
      intr_armed_q = tr.arm;
    end else begin
      case (tn_state)
        TN_IAC: begin
          if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
            tn_verb = c;
            tn_state = TN_OPT;
          end else if (c == B_SB) begin
            tn_state = TN_SB;
          end else begin
            tn_state = TN_DATA;
            to_line = (c == B_IAC);
          end
        end
        TN_OPT: begin
          if (tn_verb == B_WILL) begin
            emit_result(1'b0, 8'd0, EK_DONT, c, EV_NONE, 1'b0);
          end else if (tn_verb == B_DO) begin
            emit_result(1'b0, 8'd0, EK_WONT, c, EV_NONE, 1'b0);
          end
          tn_state = TN_DATA;
        end
        TN_SB: begin
          if (c == B_IAC) tn_state = TN_SBIAC;
        end
        TN_SBIAC: begin
          if (c == B_SE) tn_state = TN_DATA;
          else tn_state = TN_SB;
        end
        default: begin
          if (c == B_IAC) tn_state = TN_IAC;
          else to_line = 1'b1;
        end
      endcase
      if (to_line) begin
        if (c == B_ETX && intr_armed_q) begin
          intr_armed_q = 1'b0;
          intr_fired_q = 1'b1;
          line_len = 0;
          emit_result(1'b0, 8'd0, EK_INTR, 8'd0, EV_INTR, 1'b0);
        end else if (raw_sel) begin
          emit_result(1'b1, c, EK_NONE, 8'd0, EV_READABLE, 1'b0);
        end else begin
          case (c)
            B_CR, B_LF: begin
              flush_line();
              emit_result(1'b1, B_LF, EK_CRLF, 8'd0, EV_READABLE, 1'b0);
            end
            B_NUL: begin
            end
            B_ETX: begin
              while (line_len != 0) rub_char();
              emit_result(1'b0, 8'd0, EK_INTR, 8'd0, EV_NONE, 1'b0);
            end
            B_EOT: begin
              if (line_len != 0) begin
                flush_line();
                step_out[step_count - 1].event_res = EV_READABLE;
              end else begin
                emit_result(1'b0, 8'd0, EK_NONE, 8'd0, EV_EOF, 1'b0);
              end
            end
            B_BS, B_DEL: rub_char();
            B_NAK: begin
              while (line_len != 0) rub_char();
            end
            B_ETB: begin
              while (line_len != 0 && line_buf[line_len - 1] == B_SPACE) rub_char();
              while (line_len != 0 && line_buf[line_len - 1] != B_SPACE) rub_char();
            end
            default: begin
              if (c >= B_SPACE && line_len < LINE_MAX - 1) begin
                line_buf[line_len] = c;
                line_len++;
                emit_result(1'b0, 8'd0, EK_BYTE, c, EV_NONE, 1'b0);
              end
            end
          endcase
        end
      end
    end
    if (step_count == 0) emit_result(1'b0, 8'd0, EK_NONE, 8'd0, EV_NONE, 1'b0);
    step_out[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++) awaited_outputs.push_back(step_out[i]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    tld_in_t tr;
    tr.req_type = 1'b0;
    tr.data_byte = b;
    tr.arm = 1'($urandom_range(0, 1));
    pending_requests.push_back(tr);
    requests_issued++;
  endtask

  task automatic send_nomination(input logic a);
    tld_in_t tr;
    tr.req_type = 1'b1;
    tr.data_byte = 8'($urandom);
    tr.arm = a;
    pending_requests.push_back(tr);
    requests_issued++;
  endtask

  function automatic logic [7:0] printable();
    logic [7:0] b;
    b = 8'($urandom_range(32, 254));
    if (b == B_DEL || $urandom_range(0, 4) == 0) b = B_SPACE;
    return b;
  endfunction

  task automatic send_line_end();
    case ($urandom_range(0, 7))
      0, 1: send_byte(B_CR);
      2: send_byte(B_LF);
      3: send_byte(B_EOT);
      4: send_byte(B_ETX);
      5: send_byte(B_NAK);
      6: send_byte(B_ETB);
      default: begin
        send_byte(B_NUL);
        send_byte(B_CR);
      end
    endcase
  endtask

  task automatic queue_random_sequence();
    int kind;
    int len;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      if ($urandom_range(0, 7) == 0) len = $urandom_range(7, 16);
      else len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_byte(B_BS);
        else if (pick == 1) send_byte(B_DEL);
        else if (pick == 2) send_byte(B_ETB);
        else if (pick == 3) begin
          send_byte(B_IAC);
          send_byte(B_IAC);
        end else send_byte(printable());
      end
      send_line_end();
    end else if (kind < 60) begin
      send_byte(B_IAC);
      case ($urandom_range(0, 5))
        0: send_byte(B_IAC);
        1, 2: begin
          send_byte(8'(B_WILL + $urandom_range(0, 3)));
          send_byte(8'($urandom));
        end
        3: begin
          send_byte(B_SB);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
              send_byte(B_IAC);
              send_byte(8'($urandom_range(0, 239)));
            end else if (pick == 1) begin
              send_byte(B_IAC);
              send_byte(B_IAC);
            end else send_byte(8'($urandom_range(0, 254)));
          end
          send_byte(B_IAC);
          send_byte(B_SE);
        end
        default: send_byte(8'($urandom_range(0, 249)));
      endcase
    end else if (kind < 70) begin
      case ($urandom_range(0, 3))
        0: begin
          send_nomination(1'b1);
          send_byte(printable());
          send_byte(B_ETX);
          send_nomination(1'b0);
        end
        1: begin
          send_nomination(1'b1);
          send_byte(printable());
          send_line_end();
          send_nomination(1'b0);
        end
        2: send_nomination(1'b0);
        default: send_nomination(1'b1);
      endcase
    end else if (kind < 85) begin
      send_byte(8'($urandom_range(0, 31)));
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic write_mode(input logic raw);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    raw_sel = raw;
    line_len = 0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (requests_accepted != requests_issued || awaited_outputs.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, got_v);
      failures++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        discipline_step(in_data_i);
        requests_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_outputs.size() == 0) begin
          $error("unexpected transaction %h", out_data_o);
          failures++;
        end else begin
          want = awaited_outputs.pop_front();
          check_field("queue_valid", 8'(want.queue_valid), 8'(out_data_o.queue_valid));
          check_field("queue_byte", want.queue_byte, out_data_o.queue_byte);
          check_field("echo_kind", 8'(want.echo_kind), 8'(out_data_o.echo_kind));
          check_field("echo_byte", want.echo_byte, out_data_o.echo_byte);
          check_field("event_res", 8'(want.event_res), 8'(out_data_o.event_res));
          check_field("fired_status", 8'(want.fired_status), 8'(out_data_o.fired_status));
          check_field("last", 8'(want.last), 8'(out_data_o.last));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int stop_at;
    for (int i = 0; i < LINE_MAX; i++) line_buf[i] = 8'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);

    // cooked editing, eof, interrupt and option refusal
    send_byte(B_NUL);
    send_byte("h");
    send_byte(B_SPACE);
    send_byte("w");
    send_byte(B_IAC);
    send_byte(B_IAC);
    send_byte(B_BS);
    send_byte(B_ETB);
    send_byte(B_CR);
    send_byte(B_EOT);
    send_byte("q");
    send_byte(B_EOT);
    send_byte("z");
    send_byte(B_NAK);
    send_byte("k");
    send_byte(B_ETX);
    send_nomination(1'b1);
    send_byte(B_ETX);
    send_nomination(1'b0);
    send_byte(B_IAC);
    send_byte(B_WILL);
    send_byte(8'h00);
    send_byte(B_IAC);
    send_byte(B_DO);
    send_byte(8'hff);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = idle_send[p % 4];
      recv_stall_pct = idle_recv[p % 4];
      write_mode(1'((p ^ (p >> 2)) & 1));
      if (p == 0) begin
        // overfill the line store
        for (int i = 0; i < 66; i++) send_byte(printable());
        send_line_end();
      end
      stop_at = requests_issued + PHASE_ITEMS;
      while (requests_issued < stop_at) queue_random_sequence();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tld_pkg.sv
rtl/terminal_line_discipline.sv
sim/tb_terminal_line_discipline.sv
